### sv/ppst_pkg.sv
// Shared constants, types and the arctangent table of the pure pursuit steering block.
`default_nettype none
package ppst_pkg;

  localparam int ANGLE_FRAC_BITS   = 16;
  localparam int CORDIC_ITERATIONS = 20;

  localparam int AW        = ANGLE_FRAC_BITS + 5;
  localparam int ASH       = 30 - ANGLE_FRAC_BITS;
  localparam int CW        = 38;
  localparam int QW        = 35;
  localparam int MAGW      = 34;
  localparam int DW        = 34;
  localparam int SW        = 32;
  localparam int PW        = SW + DW;
  localparam int DVW       = 64;
  localparam int DIGW      = 16;
  localparam int DIV_STEPS = DVW / DIGW;
  localparam int RCW       = 24;
  localparam int RECIP_SH  = 24;
  localparam int SQW       = DW + 16;
  localparam int SQ_STEPS  = SQW / 2;
  localparam int CNT_W     = 6;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ANG_RND     = 64'd1 << (ASH - 1);

  localparam logic signed [AW-1:0] PI_A      = AW'((PI_Q30 + ANG_RND) >> ASH);
  localparam logic signed [AW-1:0] HALF_PI_A = AW'((HALF_PI_Q30 + ANG_RND) >> ASH);
  localparam logic signed [AW-1:0] NEG_PI_A  = -PI_A;
  localparam logic signed [AW-1:0] NEG_HALF_PI_A = -HALF_PI_A;
  localparam logic signed [AW-1:0] TWO_PI_A  = PI_A + PI_A;

  localparam logic [29:0]   INV_GAIN     = 30'd652032874;
  localparam logic [DW-1:0] ARRIVE_LIMIT = DW'(6554);
  localparam logic [PW-1:0] TURN_ROUND   = PW'(64'd4831838208);
  localparam logic [30:0]   OUT_MAX      = 31'h7FFFFFFF;

  // Reciprocals of 9 and 3, scaled by 2^RECIP_SH and rounded up.
  localparam logic [RCW-1:0] RECIP9 = RCW'(1864136);
  localparam logic [RCW-1:0] RECIP3 = RCW'(5592406);

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_QUAT,
    OP_YAW_INIT,
    OP_BEAR_INIT,
    OP_CORDIC,
    OP_YAW_DONE,
    OP_BEAR_DONE,
    OP_DIST,
    OP_WRAP,
    OP_SIN_INIT,
    OP_SIN_DONE,
    OP_MUL,
    OP_DIV9_INIT,
    OP_DIV_STEP,
    OP_ANG_DONE,
    OP_DIV3_INIT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SQRT_DONE,
    OP_OUT_TWIST,
    OP_OUT_STOP
  } op_e;

  typedef struct packed {
    logic cordic_last;
    logic div_last;
    logic sqrt_last;
    logic wrap_done;
    logic near;
    logic arrived;
    logic out_free;
  } status_t;

  function automatic logic signed [AW-1:0] atan_angle(input logic [4:0] idx);
    logic [31:0] q;
    case (idx)
      5'd0:  q = 32'h3243F6A8;
      5'd1:  q = 32'h1DAC6705;
      5'd2:  q = 32'h0FADBAFC;
      5'd3:  q = 32'h07F56EA6;
      5'd4:  q = 32'h03FEAB76;
      5'd5:  q = 32'h01FFD55B;
      5'd6:  q = 32'h00FFFAAA;
      5'd7:  q = 32'h007FFF55;
      5'd8:  q = 32'h003FFFEA;
      5'd9:  q = 32'h001FFFFD;
      5'd10: q = 32'h000FFFFF;
      5'd11: q = 32'h0007FFFF;
      5'd12: q = 32'h0003FFFF;
      5'd13: q = 32'h0001FFFF;
      5'd14: q = 32'h0000FFFF;
      5'd15: q = 32'h00007FFF;
      5'd16: q = 32'h00003FFF;
      5'd17: q = 32'h00001FFF;
      5'd18: q = 32'h00000FFF;
      5'd19: q = 32'h000007FF;
      5'd20: q = 32'h000003FF;
      5'd21: q = 32'h000001FF;
      5'd22: q = 32'h000000FF;
      5'd23: q = 32'h0000007F;
      5'd24: q = 32'h0000003F;
      5'd25: q = 32'h0000001F;
      5'd26: q = 32'h0000000F;
      5'd27: q = 32'h00000008;
      5'd28: q = 32'h00000004;
      5'd29: q = 32'h00000002;
      5'd30: q = 32'h00000001;
      default: q = 32'h00000000;
    endcase
    return AW'(({32'd0, q} + ANG_RND) >> ASH);
  endfunction

endpackage
`default_nettype wire

### sv/ppst_if.sv
// Request channels of the pure pursuit steering block: pose in, twist out.
`default_nettype none
interface ppst_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

interface ppst_twist_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angular_rate;
  logic [30:0]        linear_speed;
  logic               reached;
  logic               last;
  modport source (output valid, angular_rate, linear_speed, reached, last,
                  input ready);
  modport sink (input valid, angular_rate, linear_speed, reached, last,
                output ready);
endinterface
`default_nettype wire

### sv/ppst_dp.sv
// Datapath: goal registers, shared CORDIC, reciprocal constant divider, square root, output register.
`default_nettype none
module ppst_dp
  import ppst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire op_e                cmd_i,
  output status_t                 status_o,
  input  wire logic signed [31:0] pose_x_i,
  input  wire logic signed [31:0] pose_y_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_sel_i,
  input  wire logic [31:0]        cfg_wdata_i,
  output logic [31:0]             goal_x_o,
  output logic [31:0]             goal_y_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      angular_rate_o,
  output logic [30:0]             linear_speed_o,
  output logic                    reached_o,
  output logic                    last_o
);

  logic signed [31:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic               arrived_q, arrived_d, out_valid_q, out_valid_d;

  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic signed [15:0] qx_q, qx_d, qy_q, qy_d, qz_q, qz_d, qw_q, qw_d;
  logic signed [QW-1:0] num_q, num_d, den_q, den_d;
  logic               yawz_q, yawz_d, dzero_q, dzero_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [AW-1:0] cz_q, cz_d, yaw_q, yaw_d, alpha_q, alpha_d;
  logic               vec_q, vec_d, neg_q, neg_d, sneg_q, sneg_d, div9_q, div9_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MAGW-1:0]    mag_q, mag_d;
  logic [DW-1:0]      dist_q, dist_d;
  logic [SW-1:0]      sabs_q, sabs_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [DVW-1:0]     dvd_q, dvd_d;
  logic [3:0]         rem_q, rem_d;
  logic [SQW-1:0]     sqn_q, sqn_d, sqr_q, sqr_d, sqb_q, sqb_d;
  logic signed [31:0] ang_q, ang_d;
  logic [30:0]        lin_q, lin_d;
  logic signed [31:0] oang_q, oang_d;
  logic [30:0]        olin_q, olin_d;
  logic               orch_q, orch_d, olast_q, olast_d;

  logic signed [31:0] pxx, pyy, pzz, pww, pxy, pwz, pxz, pwy;
  logic signed [QW-1:0] gim, gabs, nrm;
  logic signed [32:0] dx, dy;
  logic signed [CW-1:0] vx, vy, xs, ys, sval, sabs_w;
  logic signed [AW-1:0] atan_a, bearing;
  logic               dir, out_free;
  logic [3:0]         divisor;
  logic [RCW-1:0]     recip;
  logic [DIGW+3:0]    dig_v;
  logic [DIGW+RCW+3:0] dig_p;
  logic [DIGW-1:0]    dig_q;
  logic [MAGW+29:0]   dmul;
  logic [PW-1:0]      tsum;
  logic [SQW-1:0]     sqt;

  always_comb begin
    pxx = qx_q * qx_q;
    pyy = qy_q * qy_q;
    pzz = qz_q * qz_q;
    pww = qw_q * qw_q;
    pxy = qx_q * qy_q;
    pwz = qw_q * qz_q;
    pxz = qx_q * qz_q;
    pwy = qw_q * qy_q;
    gim = (QW'(pxz) - QW'(pwy)) <<< 1;
    gabs = gim[QW-1] ? -gim : gim;
    nrm = QW'(pww) + QW'(pxx) + QW'(pyy) + QW'(pzz);
    dx = 33'(goal_x_q) - 33'(px_q);
    dy = 33'(goal_y_q) - 33'(py_q);
    if (cmd_i == OP_YAW_INIT) begin
      vx = CW'(den_q);
      vy = CW'(num_q);
    end else begin
      vx = CW'(dx);
      vy = CW'(dy);
    end
    xs = cx_q >>> cnt_q[4:0];
    ys = cy_q >>> cnt_q[4:0];
    atan_a = atan_angle(cnt_q[4:0]);
    dir = vec_q ? !cy_q[CW-1] : cz_q[AW-1];
    bearing = dzero_q ? '0 : cz_q;
    dmul = mag_q * INV_GAIN;
    sval = neg_q ? -cy_q : cy_q;
    sabs_w = sval[CW-1] ? -sval : sval;
    tsum = prod_q + TURN_ROUND;
    divisor = div9_q ? 4'd9 : 4'd3;
    recip = div9_q ? RECIP9 : RECIP3;
    dig_v = {rem_q, dvd_q[DVW-1 -: DIGW]};
    dig_p = dig_v * recip;
    dig_q = dig_p[RECIP_SH +: DIGW];
    sqt = sqr_q + sqb_q;
    out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    arrived_d = arrived_q;
    out_valid_d = out_valid_q;
    px_d = px_q; py_d = py_q;
    qx_d = qx_q; qy_d = qy_q; qz_d = qz_q; qw_d = qw_q;
    num_d = num_q; den_d = den_q; yawz_d = yawz_q; dzero_d = dzero_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    yaw_d = yaw_q; alpha_d = alpha_q;
    vec_d = vec_q; neg_d = neg_q; sneg_d = sneg_q; div9_d = div9_q;
    cnt_d = cnt_q;
    mag_d = mag_q; dist_d = dist_q; sabs_d = sabs_q; prod_d = prod_q;
    dvd_d = dvd_q; rem_d = rem_q;
    sqn_d = sqn_q; sqr_d = sqr_q; sqb_d = sqb_q;
    ang_d = ang_q; lin_d = lin_q;
    oang_d = oang_q; olin_d = olin_q; orch_d = orch_q; olast_d = olast_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (cmd_i)
      OP_LOAD: begin
        px_d = pose_x_i;
        py_d = pose_y_i;
        qx_d = quat_x_i;
        qy_d = quat_y_i;
        qz_d = quat_z_i;
        qw_d = quat_w_i;
      end
      OP_QUAT: begin
        num_d = (QW'(pxy) + QW'(pwz)) <<< 1;
        den_d = QW'(pww) + QW'(pxx) - QW'(pyy) - QW'(pzz);
        yawz_d = gabs >= nrm;
      end
      OP_YAW_INIT, OP_BEAR_INIT: begin
        vec_d = 1'b1;
        cnt_d = '0;
        if (cmd_i == OP_BEAR_INIT) begin
          dzero_d = (dx == '0) && (dy == '0);
        end
        if (vx[CW-1]) begin
          cx_d = -vx;
          cy_d = -vy;
          cz_d = vy[CW-1] ? NEG_PI_A : PI_A;
        end else begin
          cx_d = vx;
          cy_d = vy;
          cz_d = '0;
        end
      end
      OP_CORDIC: begin
        cnt_d = cnt_q + 1'b1;
        if (dir) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan_a;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan_a;
        end
      end
      OP_YAW_DONE: begin
        yaw_d = yawz_q ? '0 : cz_q;
      end
      OP_BEAR_DONE: begin
        alpha_d = bearing - yaw_q;
        mag_d = (cx_q > 0) ? MAGW'(cx_q) : '0;
      end
      OP_DIST: begin
        dist_d = DW'((dmul + (64'd1 << 29)) >> 30);
      end
      OP_WRAP: begin
        if (alpha_q > PI_A) begin
          alpha_d = alpha_q - TWO_PI_A;
        end else if (alpha_q <= NEG_PI_A) begin
          alpha_d = alpha_q + TWO_PI_A;
        end
      end
      OP_SIN_INIT: begin
        vec_d = 1'b0;
        cnt_d = '0;
        cx_d = CW'(INV_GAIN);
        cy_d = '0;
        if (alpha_q > HALF_PI_A) begin
          cz_d = alpha_q - PI_A;
          neg_d = 1'b1;
        end else if (alpha_q < NEG_HALF_PI_A) begin
          cz_d = alpha_q + PI_A;
          neg_d = 1'b1;
        end else begin
          cz_d = alpha_q;
          neg_d = 1'b0;
        end
      end
      OP_SIN_DONE: begin
        sneg_d = sval[CW-1];
        sabs_d = SW'(sabs_w);
      end
      OP_MUL: begin
        prod_d = sabs_q * dist_q;
      end
      OP_DIV9_INIT: begin
        dvd_d = DVW'(tsum >> 30);
        rem_d = '0;
        div9_d = 1'b1;
        cnt_d = '0;
      end
      OP_DIV_STEP: begin
        rem_d = 4'(dig_v - (20'(dig_q) * 20'(divisor)));
        dvd_d = {dvd_q[DVW-DIGW-1:0], dig_q};
        cnt_d = cnt_q + 1'b1;
      end
      OP_ANG_DONE: begin
        if (dvd_q > DVW'(OUT_MAX)) begin
          ang_d = sneg_q ? -{1'b0, OUT_MAX} : {1'b0, OUT_MAX};
        end else begin
          ang_d = sneg_q ? -{1'b0, dvd_q[30:0]} : {1'b0, dvd_q[30:0]};
        end
      end
      OP_DIV3_INIT: begin
        dvd_d = DVW'({dist_q, 16'd0});
        rem_d = '0;
        div9_d = 1'b0;
        cnt_d = '0;
      end
      OP_SQRT_INIT: begin
        sqn_d = SQW'(dvd_q);
        sqr_d = '0;
        sqb_d = SQW'(1) << (SQW - 2);
        cnt_d = '0;
      end
      OP_SQRT_STEP: begin
        cnt_d = cnt_q + 1'b1;
        sqb_d = sqb_q >> 2;
        if (sqn_q >= sqt) begin
          sqn_d = sqn_q - sqt;
          sqr_d = (sqr_q >> 1) + sqb_q;
        end else begin
          sqr_d = sqr_q >> 1;
        end
      end
      OP_SQRT_DONE: begin
        lin_d = (sqr_q > SQW'(OUT_MAX)) ? OUT_MAX : sqr_q[30:0];
      end
      OP_OUT_TWIST: begin
        out_valid_d = 1'b1;
        oang_d = ang_q;
        olin_d = lin_q;
        orch_d = dist_q < ARRIVE_LIMIT;
        olast_d = !(dist_q < ARRIVE_LIMIT);
      end
      OP_OUT_STOP: begin
        out_valid_d = 1'b1;
        oang_d = '0;
        olin_d = '0;
        orch_d = 1'b1;
        olast_d = 1'b1;
        arrived_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      arrived_d = 1'b0;
      if (cfg_sel_i) begin
        goal_y_d = cfg_wdata_i;
      end else begin
        goal_x_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      arrived_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      arrived_q <= arrived_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d; py_q <= py_d;
    qx_q <= qx_d; qy_q <= qy_d; qz_q <= qz_d; qw_q <= qw_d;
    num_q <= num_d; den_q <= den_d; yawz_q <= yawz_d; dzero_q <= dzero_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    yaw_q <= yaw_d; alpha_q <= alpha_d;
    vec_q <= vec_d; neg_q <= neg_d; sneg_q <= sneg_d; div9_q <= div9_d;
    cnt_q <= cnt_d;
    mag_q <= mag_d; dist_q <= dist_d; sabs_q <= sabs_d; prod_q <= prod_d;
    dvd_q <= dvd_d; rem_q <= rem_d;
    sqn_q <= sqn_d; sqr_q <= sqr_d; sqb_q <= sqb_d;
    ang_q <= ang_d; lin_q <= lin_d;
    oang_q <= oang_d; olin_q <= olin_d; orch_q <= orch_d; olast_q <= olast_d;
  end

  always_comb begin
    status_o.cordic_last = cnt_q == CNT_W'(CORDIC_ITERATIONS - 1);
    status_o.div_last = cnt_q == CNT_W'(DIV_STEPS - 1);
    status_o.sqrt_last = cnt_q == CNT_W'(SQ_STEPS - 1);
    status_o.wrap_done = !(alpha_q > PI_A) && !(alpha_q <= NEG_PI_A);
    status_o.near = dist_q < ARRIVE_LIMIT;
    status_o.arrived = arrived_q;
    status_o.out_free = out_free;
  end

  assign goal_x_o = goal_x_q;
  assign goal_y_o = goal_y_q;
  assign out_valid_o = out_valid_q;
  assign angular_rate_o = oang_q;
  assign linear_speed_o = olin_q;
  assign reached_o = orch_q;
  assign last_o = olast_q;

endmodule
`default_nettype wire

### sv/ppst_ctrl.sv
// Controller: sequences the datapath through one pose request and its twist results.
`default_nettype none
module ppst_ctrl
  import ppst_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire status_t status_i,
  output logic         in_ready_o,
  output op_e          cmd_o
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_QUAT  = 24'h000002,
    S_YAWI  = 24'h000004,
    S_YAW   = 24'h000008,
    S_YAWD  = 24'h000010,
    S_BEARI = 24'h000020,
    S_BEAR  = 24'h000040,
    S_BEARD = 24'h000080,
    S_DIST  = 24'h000100,
    S_WRAP  = 24'h000200,
    S_SINI  = 24'h000400,
    S_SIN   = 24'h000800,
    S_SIND  = 24'h001000,
    S_MUL   = 24'h002000,
    S_DIV9I = 24'h004000,
    S_DIV9  = 24'h008000,
    S_ANGD  = 24'h010000,
    S_DIV3I = 24'h020000,
    S_DIV3  = 24'h040000,
    S_SQI   = 24'h080000,
    S_SQ    = 24'h100000,
    S_SQD   = 24'h200000,
    S_OUT0  = 24'h400000,
    S_OUT1  = 24'h800000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = OP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o = OP_LOAD;
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.arrived) begin
          state_d = S_QUAT;
        end
      end
      S_QUAT: begin
        cmd_o = OP_QUAT;
        state_d = S_YAWI;
      end
      S_YAWI: begin
        cmd_o = OP_YAW_INIT;
        state_d = S_YAW;
      end
      S_YAW: begin
        cmd_o = OP_CORDIC;
        if (status_i.cordic_last) begin
          state_d = S_YAWD;
        end
      end
      S_YAWD: begin
        cmd_o = OP_YAW_DONE;
        state_d = S_BEARI;
      end
      S_BEARI: begin
        cmd_o = OP_BEAR_INIT;
        state_d = S_BEAR;
      end
      S_BEAR: begin
        cmd_o = OP_CORDIC;
        if (status_i.cordic_last) begin
          state_d = S_BEARD;
        end
      end
      S_BEARD: begin
        cmd_o = OP_BEAR_DONE;
        state_d = S_DIST;
      end
      S_DIST: begin
        cmd_o = OP_DIST;
        state_d = S_WRAP;
      end
      S_WRAP: begin
        cmd_o = OP_WRAP;
        if (status_i.wrap_done) begin
          state_d = S_SINI;
        end
      end
      S_SINI: begin
        cmd_o = OP_SIN_INIT;
        state_d = S_SIN;
      end
      S_SIN: begin
        cmd_o = OP_CORDIC;
        if (status_i.cordic_last) begin
          state_d = S_SIND;
        end
      end
      S_SIND: begin
        cmd_o = OP_SIN_DONE;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o = OP_MUL;
        state_d = S_DIV9I;
      end
      S_DIV9I: begin
        cmd_o = OP_DIV9_INIT;
        state_d = S_DIV9;
      end
      S_DIV9: begin
        cmd_o = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_ANGD;
        end
      end
      S_ANGD: begin
        cmd_o = OP_ANG_DONE;
        state_d = S_DIV3I;
      end
      S_DIV3I: begin
        cmd_o = OP_DIV3_INIT;
        state_d = S_DIV3;
      end
      S_DIV3: begin
        cmd_o = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_SQI;
        end
      end
      S_SQI: begin
        cmd_o = OP_SQRT_INIT;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o = OP_SQRT_STEP;
        if (status_i.sqrt_last) begin
          state_d = S_SQD;
        end
      end
      S_SQD: begin
        cmd_o = OP_SQRT_DONE;
        state_d = S_OUT0;
      end
      S_OUT0: begin
        if (status_i.out_free) begin
          cmd_o = OP_OUT_TWIST;
          state_d = status_i.near ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        if (status_i.out_free) begin
          cmd_o = OP_OUT_STOP;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### sv/pure_pursuit_steering.sv
// Top level of the pure pursuit steering block.
//
// Channel   Dir  Handshake       Carries
// pose_i    in   valid/ready     pose_x, pose_y, quat_x..quat_w
// twist_o   out  valid/ready     angular_rate, linear_speed, reached, last
// APB       in   psel/penable    goal_x at 0x0, goal_y at 0x4
//
// A pose request is taken only in the idle state, once the last one has gone through
// three 20-step passes of the shared CORDIC unit, a wrap of the bearing error if needed,
// two 4-step divisions by a constant on 16-bit digits and a 25-step square root. A goal
// hit adds a stop twist. The twist sits in an output register, so the next pose
// is taken while it waits; a twist that is still waiting stalls the next one. Reset
// clears the goal, the arrived flag and the state machine; there is no clearing pass.
// After arrival, poses are accepted and dropped until a goal write.
`default_nettype none
module pure_pursuit_steering
  import ppst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppst_pose_if.sink        pose_i,
  ppst_twist_if.source     twist_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  op_e         cmd;
  status_t     status;
  logic        in_ready;
  logic [31:0] goal_x, goal_y;

  ppst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pose_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  ppst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pose_x_i       (pose_i.pose_x),
    .pose_y_i       (pose_i.pose_y),
    .quat_x_i       (pose_i.quat_x),
    .quat_y_i       (pose_i.quat_y),
    .quat_z_i       (pose_i.quat_z),
    .quat_w_i       (pose_i.quat_w),
    .cfg_we_i       (psel && penable && pwrite),
    .cfg_sel_i      (paddr[2]),
    .cfg_wdata_i    (pwdata),
    .goal_x_o       (goal_x),
    .goal_y_o       (goal_y),
    .out_ready_i    (twist_o.ready),
    .out_valid_o    (twist_o.valid),
    .angular_rate_o (twist_o.angular_rate),
    .linear_speed_o (twist_o.linear_speed),
    .reached_o      (twist_o.reached),
    .last_o         (twist_o.last)
  );

  assign pose_i.ready = in_ready;
  assign prdata = paddr[2] ? goal_y : goal_x;
  assign pready = 1'b1;

endmodule
`default_nettype wire

### dv/pure_pursuit_steering_tb.sv
// Self-checking testbench of pure_pursuit_steering: random and directed poses, twist predictor.
`default_nettype none
module pure_pursuit_steering_tb
  import ppst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int          POSE_TARGET  = 1100;
  localparam int          SETTLE       = 300;
  localparam longint      INV_G        = 652032874;
  localparam longint      TURN_DIV     = 64'd9663676416;

  typedef struct {
    logic signed [31:0] px, py;
    logic signed [15:0] qx, qy, qz, qw;
  } pose_t;

  typedef struct {
    logic signed [31:0] ang;
    logic [30:0]        lin;
    logic               reached, last;
  } twist_t;

  class twist_scoreboard;
    longint gx, gy;
    bit     arrived;
    twist_t pending_twists[$];
    int     errors;

    function longint angle_of(longint q30);
      return (q30 + (64'd1 << (ASH - 1))) >>> ASH;
    endfunction

    function longint atan_of(int i);
      longint tab[20] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
                          32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
                          32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
                          32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
                          32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF};
      return angle_of(tab[i]);
    endfunction

    function longint vector_angle(longint x, longint y, output longint mag);
      longint z, xs, ys;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? angle_of(PI_Q30) : -angle_of(PI_Q30);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z += atan_of(i);
        end else begin
          x = x - ys; y = y + xs; z -= atan_of(i);
        end
      end
      mag = (x > 0) ? x : 0;
      return z;
    endfunction

    function longint sine_q30(longint z);
      longint x, y, xs, ys;
      bit neg;
      x = INV_G; y = 0; neg = 0;
      if (z > angle_of(HALF_PI_Q30)) begin
        z -= angle_of(PI_Q30); neg = 1;
      end else if (z < -angle_of(HALF_PI_Q30)) begin
        z += angle_of(PI_Q30); neg = 1;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z -= atan_of(i);
        end else begin
          x = x + ys; y = y - xs; z += atan_of(i);
        end
      end
      return neg ? -y : y;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void set_goal(int idx, logic [31:0] v);
      if (idx == 0) gx = longint'($signed(v));
      else gy = longint'($signed(v));
      arrived = 0;
    endfunction

    function void note_pose(pose_t p);
      longint qx, qy, qz, qw, num, den, gim, nrm, yaw, dx, dy, brg, mag, unused;
      longint dlen, pi_a, alpha, s, q, lin;
      twist_t t;
      if (arrived) return;
      qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
      num = 2 * (qx * qy + qw * qz);
      den = qw * qw + qx * qx - qy * qy - qz * qz;
      gim = 2 * (qx * qz - qw * qy);
      nrm = qw * qw + qx * qx + qy * qy + qz * qz;
      if (gim < 0) gim = -gim;
      yaw = (gim >= nrm) ? 0 : vector_angle(den, num, unused);
      dx = gx - longint'(p.px);
      dy = gy - longint'(p.py);
      brg = vector_angle(dx, dy, mag);
      if (dx == 0 && dy == 0) brg = 0;
      dlen = (mag * INV_G + (64'd1 << 29)) >>> 30;
      pi_a = angle_of(PI_Q30);
      alpha = brg - yaw;
      while (alpha > pi_a) alpha -= 2 * pi_a;
      while (alpha <= -pi_a) alpha += 2 * pi_a;
      s = sine_q30(alpha);
      q = ((s < 0 ? -s : s) * dlen + TURN_DIV / 2) / TURN_DIV;
      if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      lin = int_sqrt((dlen << 16) / 3);
      if (lin > 64'h7FFFFFFF) lin = 64'h7FFFFFFF;
      t.ang = 32'((s < 0) ? -q : q);
      t.lin = lin[30:0];
      t.reached = dlen < 6554;
      t.last = !t.reached;
      pending_twists.push_back(t);
      if (t.reached) begin
        t.ang = 0; t.lin = 0; t.last = 1;
        pending_twists.push_back(t);
        arrived = 1;
      end
    endfunction

    function void check_twist(twist_t got);
      twist_t e;
      if (pending_twists.size() == 0) begin
        $error("unexpected twist ang=%0d lin=%0d", got.ang, got.lin);
        errors++;
        return;
      end
      e = pending_twists.pop_front();
      if (got.ang !== e.ang) begin
        $error("angular_rate expected %0d actual %0d", e.ang, got.ang); errors++;
      end
      if (got.lin !== e.lin) begin
        $error("linear_speed expected %0d actual %0d", e.lin, got.lin); errors++;
      end
      if (got.reached !== e.reached) begin
        $error("reached expected %0b actual %0b", e.reached, got.reached); errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0b actual %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppst_pose_if  pose_ch();
  ppst_twist_if twist_ch();

  pure_pursuit_steering DUT (
    .clk_i, .rst_ni, .pose_i(pose_ch.sink), .twist_o(twist_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  twist_scoreboard sb = new();
  int unsigned     cycles;
  int              hold_cycles;
  bit              busy_free;
  int              sent;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  initial begin
    pose_ch.valid = 0;
    pose_ch.pose_x = 0; pose_ch.pose_y = 0;
    pose_ch.quat_x = 0; pose_ch.quat_y = 0; pose_ch.quat_z = 0; pose_ch.quat_w = 16384;
    twist_ch.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pure_pursuit_steering_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      twist_ch.ready <= 0;
    end else begin
      twist_ch.ready <= busy_free || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    pose_t  p;
    twist_t t;
    if (rst_ni && pose_ch.valid && pose_ch.ready) begin
      p.px = pose_ch.pose_x; p.py = pose_ch.pose_y;
      p.qx = pose_ch.quat_x; p.qy = pose_ch.quat_y;
      p.qz = pose_ch.quat_z; p.qw = pose_ch.quat_w;
      sb.note_pose(p);
    end
    if (rst_ni && twist_ch.valid && twist_ch.ready) begin
      t.ang = twist_ch.angular_rate; t.lin = twist_ch.linear_speed;
      t.reached = twist_ch.reached; t.last = twist_ch.last;
      sb.check_twist(t);
    end
  end

  task automatic write_goal(int idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_goal(idx, v);
  endtask

  task automatic send_pose(pose_t p);
    if (!busy_free && $urandom_range(99) < 35) begin
      pose_ch.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    pose_ch.valid <= 1;
    pose_ch.pose_x <= p.px; pose_ch.pose_y <= p.py;
    pose_ch.quat_x <= p.qx; pose_ch.quat_y <= p.qy;
    pose_ch.quat_z <= p.qz; pose_ch.quat_w <= p.qw;
    do @(posedge clk_i); while (!pose_ch.ready);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk_i);
    pose_ch.valid <= 0;
    while (sb.pending_twists.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_quat();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic pose_t make_pose(logic signed [31:0] x, logic signed [31:0] y,
                                      int a, int b, int c, int d);
    pose_t p;
    p.px = x; p.py = y;
    p.qx = 16'(a); p.qy = 16'(b); p.qz = 16'(c); p.qw = 16'(d);
    return p;
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int    r;
    r = $urandom_range(99);
    if (r < 10) begin
      p.px = 32'(sb.gx + $signed($urandom_range(0, 6000)) - 3000);
      p.py = 32'(sb.gy + $signed($urandom_range(0, 6000)) - 3000);
    end else if (r < 60) begin
      p.px = 32'(sb.gx + $signed($urandom_range(0, 2000000)) - 1000000);
      p.py = 32'(sb.gy + $signed($urandom_range(0, 2000000)) - 1000000);
    end else begin
      p.px = $urandom; p.py = $urandom;
    end
    p.qx = rand_quat(); p.qy = rand_quat(); p.qz = rand_quat(); p.qw = rand_quat();
    return p;
  endfunction

  initial begin
    int          phase;
    logic [31:0] g[2];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    write_goal(0, 32'h0001_0000);
    write_goal(1, 32'hFFFE_0000);
    send_pose(make_pose(0, 0, 0, 0, 0, 16384));
    send_pose(make_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384, 0, 0, 0));
    send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 0, 16384, 0, 0));
    send_pose(make_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16384, 0));
    send_pose(make_pose(0, 0, -16384, -16384, -16384, -16384));
    send_pose(make_pose(32'h0005_0000, 0, 0, 0, 0, 0));
    send_pose(make_pose(0, 32'h0003_0000, 0, 11585, 0, 11585));
    send_pose(make_pose(32'h0002_0000, 32'hFFFE_0000, 0, 0, 11585, -11585));
    send_pose(make_pose(32'hFFFF_0000, 32'hFFFE_0000, 0, 0, 16384, 0));
    send_pose(make_pose(32'h0001_0000, 32'hFFFE_0000, 0, 0, 0, 16384));
    send_pose(make_pose(0, 0, 0, 0, 0, 16384));
    drain();

    write_goal(0, 32'h7FFF_FFFF);
    write_goal(1, 32'h8000_0000);
    send_pose(make_pose(32'h8000_0000, 32'h7FFF_FFFF, 16384, 16384, 16384, 16384));
    send_pose(make_pose(32'h7FFF_F000, 32'h8000_1000, 0, 0, 0, 16384));
    send_pose(make_pose(0, 0, 0, 0, 0, 16384));
    drain();

    write_goal(0, 32'h8000_0000);
    write_goal(1, 32'h7FFF_FFFF);
    send_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, -16384, 0));
    send_pose(make_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, -16384));
    drain();

    phase = 0;
    while (sent < POSE_TARGET) begin
      int n;
      case ($urandom_range(5))
        0: begin g[0] = 32'h7FFF_FFFF; g[1] = 32'h8000_0000; end
        1: begin g[0] = 0; g[1] = 0; end
        default: begin g[0] = $urandom; g[1] = $urandom; end
      endcase
      if ($urandom_range(3) == 0) begin
        write_goal(1, g[1]);
        write_goal(0, g[0]);
      end else if ($urandom_range(2) == 0) begin
        write_goal($urandom_range(1), g[0]);
      end else begin
        write_goal(0, g[0]);
        write_goal(1, g[1]);
      end
      busy_free = (phase == 4);
      if (phase == 2) hold_cycles = 3000;
      n = $urandom_range(15, 60);
      for (int i = 0; i < n; i++) send_pose(rand_pose());
      drain();
      busy_free = 0;
      phase++;
    end

    if (sb.errors == 0 && sb.pending_twists.size() == 0) begin
      $display("pure_pursuit_steering_tb passed");
    end else begin
      $display("pure_pursuit_steering_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
